FILE: src/pip_pkg.sv
// shared types and constants for the point-in-polygon ray-cast block
package pip_pkg;

  localparam int FIELD_WIDTH     = 32;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH_DEF  = 4;
  localparam int IN_TDATA_W      = 4 * FIELD_WIDTH;
  localparam int IN_TUSER_W      = 1;
  localparam int OUT_TDATA_W     = 8;

  typedef struct packed {
    logic edge_en;   // test the edge from the previous vertex
    logic close_en;  // test the closing edge back to the ring's first vertex
    logic poly_end;  // report parity and clear it
  } pip_ctl_t;

  localparam int CTL_W = $bits(pip_ctl_t);

endpackage

FILE: src/pip_front.sv
// front end: ring tracking and classification of each incoming vertex
module pip_front import pip_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [FIELD_WIDTH-1:0]          query_x,
  input  logic [FIELD_WIDTH-1:0]          query_y,
  input  logic [FIELD_WIDTH-1:0]          vertex_x,
  input  logic [FIELD_WIDTH-1:0]          vertex_y,
  input  logic                            ring_end,
  input  logic                            polygon_end,
  output logic [8*COORD_WIDTH+CTL_W-1:0]  entry
);

  logic [COORD_WIDTH-1:0] qx, qy, vx, vy, fx, fy;
  logic [COORD_WIDTH-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                   in_ring_r;
  pip_ctl_t               ctl;

  always_comb begin
    qx = COORD_WIDTH'(query_x);
    qy = COORD_WIDTH'(query_y);
    vx = COORD_WIDTH'(vertex_x);
    vy = COORD_WIDTH'(vertex_y);
    // a vertex that opens a ring closes onto itself
    fx = in_ring_r ? first_x_r : vx;
    fy = in_ring_r ? first_y_r : vy;
    ctl.edge_en  = in_ring_r;
    ctl.close_en = ring_end | polygon_end;
    ctl.poly_end = polygon_end;
    entry = {ctl, fy, fx, prev_y_r, prev_x_r, vy, vx, qy, qx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ring_r <= 1'b0;
    end else if (accept) begin
      in_ring_r <= !(ring_end | polygon_end);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= vx;
      prev_y_r <= vy;
      if (!in_ring_r) begin
        first_x_r <= vx;
        first_y_r <= vy;
      end
    end
  end

endmodule

FILE: src/pip_fifo.sv
// short queue between the front end and the edge-test back end
module pip_fifo import pip_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       not_empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0]  level_r;

  assign rdata     = mem[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign full      = (level_r == LVL_W'(DEPTH));
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/pip_edge.sv
// pipelined exact ray/edge crossing test: differences, split products, sums, compare
module pip_edge import pip_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  input  logic signed [COORD_WIDTH-1:0] x1,
  input  logic signed [COORD_WIDTH-1:0] y1,
  input  logic signed [COORD_WIDTH-1:0] x2,
  input  logic signed [COORD_WIDTH-1:0] y2,
  input  logic                          chk,
  output logic                          hit
);

  localparam int P  = COORD_WIDTH + 1;
  localparam int LO = (P + 1) / 2;
  localparam int HI = P - LO;
  localparam int PW = 2 * P;

  // product 0 is (qx-x1)*(y2-y1), product 1 is (x2-x1)*(qy-y1)
  logic signed [P-1:0]     opa [2];
  logic signed [P-1:0]     opb [2];
  logic                    strad;

  logic [P-1:0]            a_r [2];
  logic [P-1:0]            b_r [2];
  logic                    sa_r, dpos_a_r;

  logic signed [HI-1:0]    ah [2];
  logic signed [HI-1:0]    bh [2];
  logic signed [LO:0]      al [2];
  logic signed [LO:0]      bl [2];
  logic signed [2*HI-1:0]  hh_nxt [2];
  logic signed [HI+LO:0]   hl_nxt [2];
  logic signed [HI+LO:0]   lh_nxt [2];
  logic [2*LO-1:0]         ll_nxt [2];

  logic signed [2*HI-1:0]  hh_r [2];
  logic signed [HI+LO:0]   hl_r [2];
  logic signed [HI+LO:0]   lh_r [2];
  logic [2*LO-1:0]         ll_r [2];
  logic                    sb_r, dpos_b_r;

  logic [PW-1:0]           prod_nxt [2];
  logic [PW-1:0]           hhx [2];
  logic [PW-1:0]           hlx [2];
  logic [PW-1:0]           lhx [2];
  logic [PW-1:0]           llx [2];
  logic [PW-1:0]           prod_r [2];
  logic                    sc_r, dpos_c_r;

  always_comb begin
    opa[0] = P'(qx) - P'(x1);
    opb[0] = P'(y2) - P'(y1);
    opa[1] = P'(x2) - P'(x1);
    opb[1] = P'(qy) - P'(y1);
    strad  = (y1 > qy) != (y2 > qy);
  end

  // split each operand into a signed high half and an unsigned low half
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ah[i] = a_r[i][P-1:LO];
      bh[i] = b_r[i][P-1:LO];
      al[i] = {1'b0, a_r[i][LO-1:0]};
      bl[i] = {1'b0, b_r[i][LO-1:0]};
      hh_nxt[i] = ah[i] * bh[i];
      hl_nxt[i] = ah[i] * bl[i];
      lh_nxt[i] = al[i] * bh[i];
      ll_nxt[i] = a_r[i][LO-1:0] * b_r[i][LO-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hhx[i] = PW'(hh_r[i]);
      hlx[i] = PW'(hl_r[i]);
      lhx[i] = PW'(lh_r[i]);
      llx[i] = PW'(ll_r[i]);
      prod_nxt[i] = (hhx[i] << (2 * LO)) + ((hlx[i] + lhx[i]) << LO) + llx[i];
    end
  end

  // with dy negative the inequality flips
  assign hit = sc_r & (dpos_c_r ? ($signed(prod_r[0]) < $signed(prod_r[1]))
                                : ($signed(prod_r[1]) < $signed(prod_r[0])));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        a_r[i]    <= opa[i];
        b_r[i]    <= opb[i];
        hh_r[i]   <= hh_nxt[i];
        hl_r[i]   <= hl_nxt[i];
        lh_r[i]   <= lh_nxt[i];
        ll_r[i]   <= ll_nxt[i];
        prod_r[i] <= prod_nxt[i];
      end
      sa_r     <= chk & strad;
      dpos_a_r <= !opb[0][P-1];
      sb_r     <= sa_r;
      dpos_b_r <= dpos_a_r;
      sc_r     <= sb_r;
      dpos_c_r <= dpos_b_r;
    end
  end

endmodule

FILE: src/pip_back.sv
// back end: edge-test pipelines for the previous and the closing edge, parity accumulation and result register
module pip_back import pip_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fifo_valid,
  input  logic [8*COORD_WIDTH+CTL_W-1:0] fifo_data,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_TDATA_W-1:0]         out_tdata
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] qx, qy, vx, vy, px, py, fx, fy;
  pip_ctl_t            ctl;
  pip_ctl_t            ctl_r [3];
  logic [2:0]          valid_r;
  logic                parity_r, parity_nxt;
  logic                out_valid_r, inside_r;
  logic                en, cross_edge, cross_close;

  assign {ctl, fy, fx, py, px, vy, vx, qy, qx} = fifo_data;

  // only a finished polygon blocked at the output stalls the pipeline
  assign en  = !(valid_r[2] && ctl_r[2].poly_end && out_valid_r && !out_tready);
  assign pop = en && fifo_valid;

  pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prev (
    .clk   (clk),
    .en    (en),
    .qx    (qx),
    .qy    (qy),
    .x1    (vx),
    .y1    (vy),
    .x2    (px),
    .y2    (py),
    .chk   (ctl.edge_en),
    .hit   (cross_edge)
  );

  pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
    .clk   (clk),
    .en    (en),
    .qx    (qx),
    .qy    (qy),
    .x1    (fx),
    .y1    (fy),
    .x2    (vx),
    .y2    (vy),
    .chk   (ctl.close_en),
    .hit   (cross_close)
  );

  assign parity_nxt = parity_r ^ cross_edge ^ cross_close;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, inside_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace one leaving in the same cycle
      if (en && valid_r[2] && ctl_r[2].poly_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (en) begin
        valid_r <= {valid_r[1:0], fifo_valid};
        if (valid_r[2]) begin
          if (ctl_r[2].poly_end) begin
            parity_r <= 1'b0;
          end else begin
            parity_r <= parity_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl;
      ctl_r[1] <= ctl_r[0];
      ctl_r[2] <= ctl_r[1];
      if (valid_r[2] && ctl_r[2].poly_end) begin
        inside_r <= parity_nxt;
      end
    end
  end

endmodule

FILE: src/point_in_polygon_ray_cast_top.sv
// Even-odd point-in-polygon test. Each input transfer carries one polygon vertex
// with the query point; ring_end (tuser) closes a ring and tlast closes the polygon,
// which also closes an open ring. One vertex is taken per cycle while the queue is
// not full. A vertex is written to a FIFO_DEPTH-entry queue (four by default), then
// both of its edges (from the previous vertex and, at ring end, back to the first) go
// through a three-stage exact crossing pipeline with split multiplies (difference,
// split-product and sum registers); the inside/outside result is registered after
// them. The queue absorbs the output stalling on a finished result, so input keeps
// flowing until it fills. Coordinates use the low COORD_WIDTH bits of each 32-bit field.
module point_in_polygon_ray_cast_top import pip_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // query_x, query_y, vertex_x, vertex_y
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // ring_end
  input  logic                   in_tlast,   // polygon_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // inside_res, zero fill
);

  localparam int ENTRY_W = 8 * COORD_WIDTH + CTL_W;
  localparam int LVL_W   = $clog2(FIFO_DEPTH + 1);

  logic               push, pop, fifo_valid, fifo_full;
  logic [ENTRY_W-1:0] entry, fifo_data;
  logic [LVL_W-1:0]   level;

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && in_tready;

  pip_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (push),
    .query_x     (in_tdata[FIELD_WIDTH-1:0]),
    .query_y     (in_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]),
    .vertex_x    (in_tdata[3*FIELD_WIDTH-1:2*FIELD_WIDTH]),
    .vertex_y    (in_tdata[4*FIELD_WIDTH-1:3*FIELD_WIDTH]),
    .ring_end    (in_tuser[0]),
    .polygon_end (in_tlast),
    .entry       (entry)
  );

  pip_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (entry),
    .pop       (pop),
    .rdata     (fifo_data),
    .not_empty (fifo_valid),
    .full      (fifo_full),
    .level     (level)
  );

  pip_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (fifo_valid),
    .fifo_data  (fifo_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LVL_W'(FIFO_DEPTH))
    else $error("queue level beyond depth");

  a_level_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (level == $past(level) + LVL_W'(1)))
    else $error("queue level did not rise on a lone write");

  a_level_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (level == $past(level) - LVL_W'(1)))
    else $error("queue level did not fall on a lone read");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

endmodule
